FILE: design/lru_page_frame_replacer_unit_macros.svh
// Assertion helpers shared by the replacer RTL.
`ifndef LRU_PAGE_FRAME_REPLACER_UNIT_MACROS_SVH
`define LRU_PAGE_FRAME_REPLACER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LRUPFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LRUPFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/lrupfr_pkg.sv
package lrupfr_pkg;

  localparam int MAX_FRAMES_DEF = 16;
  localparam int PAGE_BITS_DEF  = 16;

  localparam int            FIU_W       = 5;
  localparam logic [FIU_W-1:0] FIU_RESET = 5'd16;
  localparam int            FRAME_IDX_W = 4;
  localparam int            COUNT_W     = 32;

  // Lookup outcome handed from the frame table to the result stage
  typedef struct packed {
    logic                   fault;
    logic                   ev_valid;
    logic [FRAME_IDX_W-1:0] frame_idx;
  } lrupfr_res_t;

endpackage

FILE: design/lrupfr_table.sv
`include "lru_page_frame_replacer_unit_macros.svh"

module lrupfr_table
  import lrupfr_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [FIU_W-1:0]     cfg_wdata,
  input  logic                 req_en,
  input  logic [PAGE_BITS-1:0] req_page,
  output lrupfr_res_t          res,
  output logic [PAGE_BITS-1:0] res_ev_page
);

  localparam int IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int RANK_W = IDX_W;
  localparam int N_W    = $clog2(MAX_FRAMES + 1);
  localparam int CMP_W  = (N_W > FIU_W) ? N_W : FIU_W;

  logic [FIU_W-1:0]     fiu_r;
  logic [MAX_FRAMES-1:0] valid_r;
  logic [RANK_W-1:0]    rank_r [MAX_FRAMES];
  logic [PAGE_BITS-1:0] page_r [MAX_FRAMES];

  logic [CMP_W-1:0]      n_eff;
  logic [MAX_FRAMES-1:0] act;
  logic [MAX_FRAMES-1:0] hit_vec, empty_vec, lru_vec;
  logic [IDX_W-1:0]      hit_idx, empty_idx, lru_idx, f;
  logic                  hit, found_empty;
  logic [RANK_W-1:0]     hit_rank, lru_rank;
  logic [MAX_FRAMES-1:0] valid_nxt;
  logic [RANK_W-1:0]     rank_nxt [MAX_FRAMES];

  // Frame count of 0 behaves as 1, anything above the table size as the table size.
  always_comb begin
    logic [CMP_W-1:0] fiu_ext;
    fiu_ext = CMP_W'(fiu_r);
    if (fiu_ext == '0) begin
      n_eff = CMP_W'(1);
    end else if (fiu_ext > CMP_W'(MAX_FRAMES)) begin
      n_eff = CMP_W'(MAX_FRAMES);
    end else begin
      n_eff = fiu_ext;
    end
  end

  // Valid ranks form a permutation 0..k-1, so the LRU frame of a full table
  // is the one ranked n-1.
  assign lru_rank = RANK_W'(n_eff - CMP_W'(1));

  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      act[i]       = CMP_W'(i) < n_eff;
      hit_vec[i]   = act[i] & valid_r[i] & (page_r[i] == req_page);
      empty_vec[i] = act[i] & ~valid_r[i];
      lru_vec[i]   = act[i] & (rank_r[i] == lru_rank);
    end
  end

  // Lowest-numbered match wins
  always_comb begin
    hit_idx   = '0;
    empty_idx = '0;
    lru_idx   = '0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (empty_vec[i]) begin
        empty_idx = IDX_W'(i);
      end
      if (lru_vec[i]) begin
        lru_idx = IDX_W'(i);
      end
    end
  end

  assign hit         = |hit_vec;
  assign found_empty = |empty_vec;
  assign hit_rank    = rank_r[hit_idx];

  always_comb begin
    priority if (hit) begin
      f = hit_idx;
    end else if (found_empty) begin
      f = empty_idx;
    end else begin
      f = lru_idx;
    end
  end

  // On a hit only frames more recent than the hit one age; on a fault all age.
  always_comb begin
    valid_nxt = valid_r;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      rank_nxt[i] = rank_r[i];
      if (act[i] && valid_r[i] && (IDX_W'(i) != f) &&
          (!hit || (rank_r[i] < hit_rank)) &&
          (rank_r[i] < RANK_W'(MAX_FRAMES - 1))) begin
        rank_nxt[i] = rank_r[i] + RANK_W'(1);
      end
    end
    rank_nxt[f]  = '0;
    valid_nxt[f] = 1'b1;
  end

  always_comb begin
    res.fault     = ~hit;
    res.ev_valid  = ~hit & ~found_empty;
    res.frame_idx = FRAME_IDX_W'(f);
    res_ev_page   = res.ev_valid ? page_r[f] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fiu_r   <= FIU_RESET;
      valid_r <= '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        rank_r[i] <= '0;
      end
    end else if (cfg_we) begin
      fiu_r   <= cfg_wdata;
      valid_r <= '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        rank_r[i] <= '0;
      end
    end else if (req_en) begin
      valid_r <= valid_nxt;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_en && !hit) begin
      page_r[f] <= req_page;
    end
  end

  `LRUPFR_ASSERT_NOW(a_valid_in_active, 1'b1, (valid_r & ~act) == '0, "valid frame outside active set")
  `LRUPFR_ASSERT_NOW(a_hit_unique, 1'b1, $onehot0(hit_vec), "page resident in two frames")
  `LRUPFR_ASSERT_NOW(a_lru_unique, req_en && !hit && !found_empty, $onehot(lru_vec), "no single LRU frame in full table")

endmodule

FILE: design/lru_page_frame_replacer_unit.sv
// LRU page replacer: one page request in, one hit/fault result out.
// Result path: the item loads the input register, then the table is searched
// and updated into the result register.
// Throughput: one item per cycle while the result side keeps up.
// Reset (rst_n, synchronous, active low): table empty, 16 active frames,
// fault count zero. A frame-count write empties the table, keeps the count.
`include "lru_page_frame_replacer_unit_macros.svh"

module lru_page_frame_replacer_unit
  import lrupfr_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [FIU_W-1:0]      cfg_wdata,  // frames_in_use
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [((PAGE_BITS + 7) / 8) * 8 - 1:0] in_tdata,  // page
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // frame_index, evicted_valid, evicted_page, fault_count
  output logic [((FRAME_IDX_W + 1 + PAGE_BITS + COUNT_W + 7) / 8) * 8 - 1:0] out_tdata,
  output logic                  out_tuser   // fault
);

  localparam int OUT_W = ((FRAME_IDX_W + 1 + PAGE_BITS + COUNT_W + 7) / 8) * 8;

  logic                  in_valid_r;
  logic [PAGE_BITS-1:0]  in_page_r;
  logic                  advance;

  lrupfr_res_t           res;
  logic [PAGE_BITS-1:0]  ev_page;

  logic [COUNT_W-1:0]    cnt_r, cnt_nxt;

  logic                  out_valid_r;
  logic                  out_fault_r;
  logic                  out_evv_r;
  logic [FRAME_IDX_W-1:0] out_idx_r;
  logic [PAGE_BITS-1:0]  out_evp_r;
  logic [COUNT_W-1:0]    out_cnt_r;

  assign advance   = in_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~in_valid_r | advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_page_r <= in_tdata[PAGE_BITS-1:0];
    end
  end

  lrupfr_table #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_table (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .req_en      (advance),
    .req_page    (in_page_r),
    .res         (res),
    .res_ev_page (ev_page)
  );

  // Saturating fault counter
  assign cnt_nxt = (res.fault && (cnt_r != '1)) ? cnt_r + COUNT_W'(1) : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (advance) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_fault_r <= res.fault;
      out_evv_r   <= res.ev_valid;
      out_idx_r   <= res.frame_idx;
      out_evp_r   <= ev_page;
      out_cnt_r   <= cnt_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_fault_r;
  assign out_tdata  = OUT_W'({out_cnt_r, out_evp_r, out_evv_r, out_idx_r});

  `LRUPFR_ASSERT_NOW(a_evict_is_fault, out_valid_r && out_evv_r, out_fault_r, "eviction without fault")
  `LRUPFR_ASSERT_NOW(a_evp_zero, out_valid_r && !out_evv_r, out_evp_r == '0, "evicted page set without eviction")
  `LRUPFR_ASSERT_NOW(a_count_nonzero, out_valid_r && out_fault_r, out_cnt_r != '0, "fault reported with zero count")

endmodule

FILE: bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lrupfr_pkg::*;

  localparam int PAGE_W     = PAGE_BITS_DEF;
  localparam int NUM_FRAMES = MAX_FRAMES_DEF;
  localparam int OUT_BITS   = 56;  // 53 bits of fields, padded to 7 bytes
  localparam int NUM_PHASES = 12;
  localparam int PHASE_LEN  = 128;

  localparam logic [FIU_W-1:0] PHASE_FRAMES [NUM_PHASES] =
    '{5'd31, 5'd16, 5'd1, 5'd17, 5'd3, 5'd8, 5'd15, 5'd4, 5'd0, 5'd12, 5'd6, 5'd2};

  typedef enum int {READY_ALWAYS, READY_MOSTLY, READY_RARELY, READY_PERIODIC} ready_mode_t;

  typedef struct packed {
    logic                   fault;
    logic [FRAME_IDX_W-1:0] frame_idx;
    logic                   ev_valid;
    logic [PAGE_W-1:0]      ev_page;
    logic [COUNT_W-1:0]     fault_count;
  } replace_outcome_t;

  class replacer_scoreboard;
    int unsigned        frames_cfg;
    logic [PAGE_W-1:0]  page_of [NUM_FRAMES];
    bit                 valid_of [NUM_FRAMES];
    logic [3:0]         rank_of [NUM_FRAMES];
    logic [COUNT_W-1:0] fault_total;
    replace_outcome_t   outcomes_due [$];
    int unsigned        requests, hits, evictions, mismatches;

    function new();
      frames_cfg  = NUM_FRAMES;
      fault_total = '0;
      clear_table();
    endfunction

    function void clear_table();
      foreach (valid_of[i]) begin
        valid_of[i] = 1'b0;
        rank_of[i]  = '0;
        page_of[i]  = '0;
      end
    endfunction

    function void set_frames(logic [FIU_W-1:0] v);
      frames_cfg = v;
      clear_table();
    endfunction

    function int unsigned pending();
      return outcomes_due.size();
    endfunction

    // frame f becomes most recent; valid frames newer than its old rank
    // (all of them on a fill) age by one, saturating
    function void promote(int n, int f, bit was_valid, int unsigned old_rank);
      for (int i = 0; i < n; i++) begin
        if (i != f && valid_of[i] && (!was_valid || rank_of[i] < old_rank)
            && rank_of[i] != 4'hF)
          rank_of[i]++;
      end
      rank_of[f]  = '0;
      valid_of[f] = 1'b1;
    endfunction

    function void note_request(logic [PAGE_W-1:0] page);
      replace_outcome_t r;
      int n, f, best;
      bit hit, empty;
      n = (frames_cfg == 0) ? 1 : (frames_cfg > NUM_FRAMES) ? NUM_FRAMES : frames_cfg;
      r = '0;
      f = 0;
      hit = 1'b0;
      empty = 1'b0;
      for (int i = 0; i < n && !hit; i++) begin
        if (valid_of[i] && page_of[i] == page) begin
          hit = 1'b1;
          f = i;
        end
      end
      if (hit) begin
        promote(n, f, 1'b1, rank_of[f]);
        hits++;
      end else begin
        for (int i = 0; i < n && !empty; i++) begin
          if (!valid_of[i]) begin
            empty = 1'b1;
            f = i;
          end
        end
        if (empty) begin
          promote(n, f, 1'b0, 0);
        end else begin
          // ties go to the lowest frame
          best = 0;
          f = 0;
          for (int i = 0; i < n; i++) begin
            if (rank_of[i] > best) begin
              best = rank_of[i];
              f = i;
            end
          end
          r.ev_valid = 1'b1;
          r.ev_page  = page_of[f];
          evictions++;
          promote(n, f, 1'b1, NUM_FRAMES);
        end
        page_of[f] = page;
        if (fault_total != '1)
          fault_total++;
        r.fault = 1'b1;
      end
      r.frame_idx   = f[FRAME_IDX_W-1:0];
      r.fault_count = fault_total;
      outcomes_due.push_back(r);
      requests++;
    endfunction

    function void check_result(logic fault, logic [OUT_BITS-1:0] data);
      replace_outcome_t want, got;
      // tdata: frame_index [3:0], evicted_valid [4], evicted_page [20:5],
      // fault_count [52:21], zero pad above
      got = {fault, data[3:0], data[4], data[20:5], data[52:21]};
      if (outcomes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing outstanding: fault %0b frame %0d ev %0b/%h cnt %0d",
                   $realtime, got.fault, got.frame_idx, got.ev_valid, got.ev_page,
                   got.fault_count);
        return;
      end
      want = outcomes_due.pop_front();
      if (got.fault !== want.fault || got.frame_idx !== want.frame_idx
          || got.ev_valid !== want.ev_valid || got.ev_page !== want.ev_page
          || got.fault_count !== want.fault_count || data[OUT_BITS-1:53] !== '0) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: mismatch exp/act: fault %0b/%0b frame %0d/%0d evicted %0b/%0b ",
                    "page %h/%h count %0d/%0d pad %b"},
                   $realtime, want.fault, got.fault, want.frame_idx, got.frame_idx,
                   want.ev_valid, got.ev_valid, want.ev_page, got.ev_page,
                   want.fault_count, got.fault_count, data[OUT_BITS-1:53]);
      end
    endfunction
  endclass

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                cfg_we     = 1'b0;
  logic [FIU_W-1:0]    cfg_wdata  = '0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [PAGE_W-1:0]   in_tdata   = '0;    // page
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_BITS-1:0] out_tdata;          // frame_index, evicted_valid, evicted_page, fault_count
  logic                out_tuser;          // fault

  replacer_scoreboard sb = new();
  int          burst_left = 0;
  ready_mode_t ready_mode = READY_ALWAYS;
  int          mode_left  = 0;
  int          settings   = 1;

  always #4 clk = ~clk;

  lru_page_frame_replacer_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_request(in_tdata);
      if (out_tvalid && out_tready)
        sb.check_result(out_tuser, out_tdata);
    end
  end

  // receiver back-pressure, switching between modes every so often
  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      mode_left  = $urandom_range(16, 200);
    end else begin
      mode_left--;
    end
    case (ready_mode)
      READY_ALWAYS: out_tready <= 1'b1;
      READY_MOSTLY: out_tready <= ($urandom_range(0, 3) != 0);
      READY_RARELY: out_tready <= ($urandom_range(0, 3) == 0);
      default:      out_tready <= (mode_left % 5 != 0);
    endcase
  end

  task automatic send_page(input logic [PAGE_W-1:0] page);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= page;
    do @(posedge clk); while (!in_tready);
    burst_left--;
  endtask

  // drain, then rewrite the frame count (which also empties the table)
  task automatic set_frame_count(input logic [FIU_W-1:0] frames);
    in_tvalid <= 1'b0;
    // wait so the last accepted item is surely noted before draining
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= frames;
    @(posedge clk);
    sb.set_frames(frames);
    cfg_we <= 1'b0;
    settings++;
  endtask

  initial begin
    logic [FIU_W-1:0]  frames;
    logic [PAGE_W-1:0] base, page, last;
    int active, pool, pick;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset table: 16 frames, extreme page values, hits on both
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h5555);
    send_page(16'hAAAA);
    send_page(16'h0000);

    // single frame: every new page after the first evicts
    set_frame_count(5'd1);
    send_page(16'd7);
    send_page(16'd7);
    send_page(16'd9);
    send_page(16'd7);

    // zero frames behaves as one
    set_frame_count(5'd0);
    send_page(16'd3);
    send_page(16'd3);
    send_page(16'd4);

    // two frames: hit refreshes recency, eviction picks the older one
    set_frame_count(5'd2);
    send_page(16'd1);
    send_page(16'd2);
    send_page(16'd1);
    send_page(16'd3);
    send_page(16'd2);

    for (int p = 0; p < NUM_PHASES; p++) begin
      frames = (p == NUM_PHASES - 1) ? FIU_W'($urandom_range(0, 31)) : PHASE_FRAMES[p];
      set_frame_count(frames);
      active = (frames == 0) ? 1 : (frames > NUM_FRAMES) ? NUM_FRAMES : frames;
      // working set a little larger than the table keeps hits and evictions mixed
      base = $urandom_range(0, 65535);
      pool = active + $urandom_range(0, 4);
      last = base;
      for (int k = 0; k < PHASE_LEN; k++) begin
        pick = $urandom_range(0, 9);
        if (pick == 0)
          page = $urandom_range(0, 65535);
        else if (pick == 1)
          page = last;
        else
          page = base + $urandom_range(0, pool - 1);
        send_page(page);
        last = page;
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("summary: %0d page requests over %0d frame-count settings (0 through 31)",
             sb.requests, settings);
    $display("summary: %0d hits, %0d faults, %0d evictions, %0d mismatches",
             sb.hits, sb.fault_total, sb.evictions, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/lrupfr_pkg.sv
design/lrupfr_table.sv
design/lru_page_frame_replacer_unit.sv
bench/testbench.sv
